/* rtl/encoder_electrical_angle_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the encoder electrical angle block
// Concurrent checks sampled on the rising clock edge, muted during reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_ELECTRICAL_ANGLE_ASSERT_SVH
`define ENCODER_ELECTRICAL_ANGLE_ASSERT_SVH

// Same-cycle implication.
`define EEA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define EEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/eea_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eea_pkg
// Shared constants, codes and types of the encoder electrical angle block.
// ----------------------------------------------------------------------------
package eea_pkg;

   // Default datapath widths
   localparam int COUNT_BITS_DEF = 16;
   localparam int ANGLE_BITS_DEF = 16;

   // Register widths
   localparam int CPR_BITS       = 16;
   localparam int PP_BITS        = 7;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNTS_PER_REV = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLE_PAIRS     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REVERSE_DIR    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERSIST_OFFSET = 2'd3;

   // Register reset values
   localparam logic [CPR_BITS-1:0]      CPR_RESET     = 16'd4096;
   localparam logic [PP_BITS-1:0]       PP_RESET      = 7'd7;
   localparam logic [CSR_DATA_BITS-1:0] PERSIST_RESET = 16'd0;

   // Request actions
   localparam int ACTION_BITS = 2;
   localparam logic [ACTION_BITS-1:0] ACT_READ      = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_CALIBRATE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_RESTORE   = 2'd2;

   // Result of one compare-subtract step
   typedef struct packed {
      logic [CPR_BITS-1:0] rem;
      logic                qbit;
   } div_step_type;

endpackage

/* rtl/eea_divstep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eea_divstep
// One restoring division step: shift in a bit, compare, subtract.
// ----------------------------------------------------------------------------
module eea_divstep (
   input  logic [eea_pkg::CPR_BITS-1:0] rem_in,
   input  logic                         bit_in,
   input  logic [eea_pkg::CPR_BITS-1:0] divisor,
   output eea_pkg::div_step_type        step
);

   logic [eea_pkg::CPR_BITS:0] partial;
   logic [eea_pkg::CPR_BITS:0] diff;
   logic                       ge;

   assign partial = {rem_in, bit_in};
   assign diff    = partial - {1'b0, divisor};
   assign ge      = (partial >= {1'b0, divisor});

   always_comb begin
      step.qbit = ge;
      step.rem  = ge ? diff[eea_pkg::CPR_BITS-1:0] : partial[eea_pkg::CPR_BITS-1:0];
   end

endmodule

/* rtl/encoder_electrical_angle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_electrical_angle
// Encoder count to electrical angle with calibration offset handling.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): an action (read, calibrate, restore), the encoder
//   count and a saved offset. A request is taken when req_valid is high and
//   req_stall is low. Response channel (rsp_*): electrical angle, raw angle,
//   calibration offset and the needs-calibration flag, one response per
//   request, taken when rsp_valid is high and rsp_stall is low.
//   One request at a time: the block takes no new request until the
//   response is loaded, and the next request may be taken the cycle after
//   the response is loaded. A single compare-subtract unit first reduces
//   count * pole_pairs modulo counts_per_rev one bit a cycle, then yields
//   the turn fraction one quotient bit a cycle.
//   Reset restores the register defaults, zeroes the calibration offset and
//   raises needs_calibration. A stalled response holds in the output
//   register; the next request is still taken and computed, and waits in its
//   final step until the output register frees up.
//   The user must write configuration (csr_*) only while no request is in
//   flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module encoder_electrical_angle #(
   parameter int COUNT_BITS = eea_pkg::COUNT_BITS_DEF,
   parameter int ANGLE_BITS = eea_pkg::ANGLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration port
   input  logic                               csr_we,
   input  logic [eea_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [eea_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [eea_pkg::ACTION_BITS-1:0]    req_action,
   input  logic [COUNT_BITS-1:0]              req_encoder_count,
   input  logic [ANGLE_BITS-1:0]              req_offset_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ANGLE_BITS-1:0]              rsp_elec_angle,
   output logic [ANGLE_BITS-1:0]              rsp_raw_angle,
   output logic [ANGLE_BITS-1:0]              rsp_cal_offset,
   output logic                               rsp_needs_calibration
);

`include "encoder_electrical_angle_assert.svh"

   localparam int PROD_BITS = COUNT_BITS + eea_pkg::PP_BITS;
   localparam int MAX_STEPS = (PROD_BITS > ANGLE_BITS) ? PROD_BITS : ANGLE_BITS;
   localparam int CNT_BITS  = $clog2(MAX_STEPS + 1);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MOD  = 2'd1;
   localparam logic [1:0] ST_FRAC = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [eea_pkg::CPR_BITS-1:0]      cpr_ff;
   logic [eea_pkg::PP_BITS-1:0]       pole_pairs_ff;
   logic                              reverse_ff;
   logic [eea_pkg::CSR_DATA_BITS-1:0] persist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff        <= eea_pkg::CPR_RESET;
         pole_pairs_ff <= eea_pkg::PP_RESET;
         reverse_ff    <= 1'b0;
         persist_ff    <= eea_pkg::PERSIST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            eea_pkg::CSR_COUNTS_PER_REV: cpr_ff        <= csr_wdata[eea_pkg::CPR_BITS-1:0];
            eea_pkg::CSR_POLE_PAIRS:     pole_pairs_ff <= csr_wdata[eea_pkg::PP_BITS-1:0];
            eea_pkg::CSR_REVERSE_DIR:    reverse_ff    <= csr_wdata[0];
            eea_pkg::CSR_PERSIST_OFFSET: persist_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------------
   logic [1:0]                        state_ff, state_in;
   logic [CNT_BITS-1:0]               cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]              prod_ff, prod_in;
   logic [eea_pkg::CPR_BITS-1:0]      rem_ff, rem_in;
   logic [ANGLE_BITS-1:0]             quot_ff, quot_in;
   logic [eea_pkg::ACTION_BITS-1:0]   action_ff, action_in;
   logic [ANGLE_BITS-1:0]             saved_off_ff, saved_off_in;

   // Persistent state
   logic [ANGLE_BITS-1:0]             offset_ff, offset_in;
   logic                              uncal_ff, uncal_in;

   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_BITS-1:0]             elec_ff, elec_in;
   logic [ANGLE_BITS-1:0]             raw_ff, raw_in;

   logic                              req_accept;
   logic                              load_out;
   logic                              step_bit;
   eea_pkg::div_step_type             step;

   // Shared compare-subtract unit: modulo pass, then fraction pass
   assign step_bit = (state_ff == ST_MOD) ? prod_ff[PROD_BITS-1] : 1'b0;

   eea_divstep u_divstep (
      .rem_in  (rem_ff),
      .bit_in  (step_bit),
      .divisor (cpr_ff),
      .step    (step)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   // Finish only when the output register is empty or being drained
   assign load_out   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // ---------------------------------------------------------------------
   // Angle post-processing, evaluated while finishing
   // ---------------------------------------------------------------------
   logic [ANGLE_BITS+eea_pkg::CSR_DATA_BITS-1:0] persist_ext;
   logic [ANGLE_BITS-1:0] frac;
   logic [ANGLE_BITS-1:0] dir_frac;
   logic [ANGLE_BITS-1:0] raw_angle;

   assign persist_ext = {{ANGLE_BITS{1'b0}}, persist_ff};
   // Zero counts per turn gives a zero fraction
   assign frac      = (cpr_ff == '0) ? '0 : quot_ff;
   assign dir_frac  = reverse_ff ? ('0 - frac) : frac;
   assign raw_angle = dir_frac - persist_ext[ANGLE_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      action_in    = action_ff;
      saved_off_in = saved_off_ff;
      offset_in    = offset_ff;
      uncal_in     = uncal_ff;
      elec_in      = elec_ff;
      raw_in       = raw_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // Product fits COUNT_BITS + 7 bits (7-bit pole pair count); reduce from the top bit
               prod_in      = PROD_BITS'(req_encoder_count) * PROD_BITS'(pole_pairs_ff);
               rem_in       = '0;
               cnt_in       = CNT_BITS'(PROD_BITS - 1);
               action_in    = req_action;
               saved_off_in = req_offset_value;
               state_in     = ST_MOD;
            end
         end
         ST_MOD: begin
            rem_in  = step.rem;
            prod_in = {prod_ff[PROD_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               cnt_in   = CNT_BITS'(ANGLE_BITS - 1);
               state_in = ST_FRAC;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_FRAC: begin
            // Remainder from the modulo pass is the dividend's high part
            rem_in  = step.rem;
            quot_in = {quot_ff[ANGLE_BITS-2:0], step.qbit};
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               case (action_ff)
                  eea_pkg::ACT_CALIBRATE: begin
                     offset_in = '0 - raw_angle;
                     uncal_in  = 1'b0;
                  end
                  eea_pkg::ACT_RESTORE: begin
                     offset_in = saved_off_ff;
                     uncal_in  = 1'b0;
                  end
                  default: ;  // read, and the unused code, leave state alone
               endcase
               raw_in       = raw_angle;
               elec_in      = raw_angle + offset_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= '0;
         uncal_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         offset_ff    <= offset_in;
         uncal_ff     <= uncal_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      action_ff    <= action_in;
      saved_off_ff <= saved_off_in;
      elec_ff      <= elec_in;
      raw_ff       <= raw_in;
   end

   // Drive response ports
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_elec_angle        = elec_ff;
   assign rsp_raw_angle         = raw_ff;
   assign rsp_cal_offset        = offset_ff;
   assign rsp_needs_calibration = uncal_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `EEA_ASSERT_NEXT(a_accept_starts_mod, clock, reset, req_accept,
      (state_ff == ST_MOD) && (cnt_ff == CNT_BITS'(PROD_BITS - 1)),
      "accepted request did not start the modulo pass")
   `EEA_ASSERT_NOW(a_rem_below_divisor, clock, reset,
      (state_ff == ST_FRAC) && (cpr_ff != '0), rem_ff < cpr_ff,
      "remainder reached the divisor in the fraction pass")
   `EEA_ASSERT_NEXT(a_cal_zero_angle, clock, reset,
      load_out && (action_ff == eea_pkg::ACT_CALIBRATE),
      (rsp_elec_angle == '0) && !rsp_needs_calibration,
      "calibrate response has nonzero electrical angle")
   `EEA_ASSERT_NEXT(a_cal_sticky, clock, reset, !uncal_ff, !uncal_ff,
      "needs-calibration flag came back after being cleared")

endmodule
